/* design/lsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types and constants for the LIFO stack with duplicate-checked push.
// ----------------------------------------------------------------------------
package lsu_pkg;

    // Fixed port widths
    localparam int KEY_PORT_W   = 64;
    localparam int COUNT_PORT_W = 7;
    localparam int OPCODE_W     = 3;
    localparam int STATUS_W     = 2;

    // Defaults for the top-level parameters
    localparam int DEFAULT_DEPTH     = 64;
    localparam int DEFAULT_KEY_WIDTH = 64;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_PUSH        = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_UNIQUE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP         = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_MANY    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK        = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd3;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
        logic cmp;
    } cell_ctrl_t;

endpackage

/* design/lifo_stack_unique_push_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_unique_push_unit
// LIFO stack of keys built as a chain of slot cells, top in cell 0, with a
// push that is dropped when the key is already stored.
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_ready   opcode, key_value, pop_count
//   result    out        out_valid / out_ready key_out, has_key, last_of_run,
//                                              depth_now, empty_now, status
//
// Push, pop, peek and unused codes: result registered in the cycle after the
// request. Push if absent: the per-cell compare is registered and then ORed
// across the chain. Pop many: one popped key per cycle while output is free.
// A request is taken when the sequencer is idle and the result register is
// free or drained in that cycle; a stalled result holds the sequencer.
// Reset clears the depth and the sequencer; slot contents are left as is.
// ----------------------------------------------------------------------------
module lifo_stack_unique_push_unit #(
    parameter int DEPTH     = lsu_pkg::DEFAULT_DEPTH,
    parameter int KEY_WIDTH = lsu_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lsu_pkg::OPCODE_W-1:0]       opcode,
    input  logic [lsu_pkg::KEY_PORT_W-1:0]     key_value,
    input  logic [lsu_pkg::COUNT_PORT_W-1:0]   pop_count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lsu_pkg::KEY_PORT_W-1:0]     key_out,
    output logic                               has_key,
    output logic                               last_of_run,
    output logic [lsu_pkg::COUNT_PORT_W-1:0]   depth_now,
    output logic                               empty_now,
    output logic [lsu_pkg::STATUS_W-1:0]       status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_CHECK  = 3'b010,
        S_POPRUN = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               remaining_reg, remaining_next;
    logic [KEY_WIDTH-1:0]           key_hold_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [lsu_pkg::KEY_PORT_W-1:0] out_key_reg;
    logic                           out_has_reg;
    logic                           out_last_reg;
    logic [CNT_W-1:0]               out_depth_reg;
    logic [lsu_pkg::STATUS_W-1:0]   out_status_reg;

    lsu_pkg::cell_ctrl_t            ctrl;
    logic [KEY_WIDTH-1:0]           key_bus;
    logic [KEY_WIDTH-1:0]           cell_data [DEPTH];
    logic [DEPTH-1:0]               cell_match;

    logic                           out_free;
    logic                           accept;
    logic                           full;
    logic                           empty;
    logic [CNT_W-1:0]               pop_run;

    logic                           out_load;
    logic [KEY_WIDTH-1:0]           ld_key;
    logic                           ld_has;
    logic                           ld_last;
    logic [lsu_pkg::STATUS_W-1:0]   ld_status;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] above;
        logic [KEY_WIDTH-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = key_bus;
        end
        else
        begin : g_mid
            assign above = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign below = cell_data[i];
        end
        else
        begin : g_up
            assign below = cell_data[i+1];
        end

        lsu_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk    (clk),
            .ctrl   (ctrl),
            .count  (count_reg),
            .key_in (key_bus),
            .above  (above),
            .below  (below),
            .data   (cell_data[i]),
            .match  (cell_match[i])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;

    // Pop-many run length, clipped to the current depth
    assign pop_run = (pop_count < lsu_pkg::COUNT_PORT_W'(count_reg))
                   ? pop_count[CNT_W-1:0] : count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        ctrl           = '0;
        key_bus        = key_value[KEY_WIDTH-1:0];
        out_load       = 1'b0;
        ld_key         = '0;
        ld_has         = 1'b0;
        ld_last        = 1'b1;
        ld_status      = lsu_pkg::STAT_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        lsu_pkg::OP_PUSH:
                        begin
                            out_load = 1'b1;
                            if (full)
                            begin
                                ld_status = lsu_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctrl.push  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        lsu_pkg::OP_PUSH_UNIQUE:
                        begin
                            ctrl.cmp   = 1'b1;
                            state_next = S_CHECK;
                        end
                        lsu_pkg::OP_POP:
                        begin
                            out_load = 1'b1;
                            if (empty)
                            begin
                                ld_status = lsu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ld_key     = cell_data[0];
                                ld_has     = 1'b1;
                                ctrl.pop   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        lsu_pkg::OP_POP_MANY:
                        begin
                            // Zero run: no result at all
                            if (pop_run != '0)
                            begin
                                remaining_next = pop_run;
                                state_next     = S_POPRUN;
                            end
                        end
                        lsu_pkg::OP_PEEK:
                        begin
                            out_load = 1'b1;
                            if (empty)
                            begin
                                ld_status = lsu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ld_key = cell_data[0];
                                ld_has = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                key_bus = key_hold_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    // Duplicate wins over full
                    if (|cell_match)
                    begin
                        ld_status = lsu_pkg::STAT_DUP;
                    end
                    else if (full)
                    begin
                        ld_status = lsu_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_POPRUN:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    ld_key         = cell_data[0];
                    ld_has         = 1'b1;
                    ld_last        = remaining_reg == CNT_W'(1);
                    ctrl.pop       = 1'b1;
                    count_next     = count_reg - 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                    if (ld_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold the key for the compare, load results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_hold_reg <= key_value[KEY_WIDTH-1:0];
        end
        if (out_load)
        begin
            out_key_reg    <= lsu_pkg::KEY_PORT_W'(ld_key);
            out_has_reg    <= ld_has;
            out_last_reg   <= ld_last;
            out_depth_reg  <= count_next;
            out_status_reg <= ld_status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign key_out     = out_key_reg;
    assign has_key     = out_has_reg;
    assign last_of_run = out_last_reg;
    assign depth_now   = lsu_pkg::COUNT_PORT_W'(out_depth_reg);
    assign empty_now   = out_depth_reg == '0;
    assign status      = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack depth above capacity");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POPRUN) |-> (remaining_reg != '0) && (count_reg != '0))
        else $error("pop run active with nothing left to pop");

    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POPRUN && out_free)
        |=> (count_reg == $past(count_reg) - 1'b1) && out_valid_reg && out_has_reg)
        else $error("pop run step did not pop and emit");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POPRUN && out_free && remaining_reg == CNT_W'(1))
        |=> (state_reg == S_IDLE) && out_last_reg)
        else $error("pop run did not end on its last key");

    a_no_key_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != lsu_pkg::STAT_OK) |-> !out_has_reg)
        else $error("error result carries a key");

endmodule

/* design/lsu_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_cell
// One stack slot: holds a key, shifts down on push and up on pop, and
// registers a match flag against the broadcast key on a compare.
// ----------------------------------------------------------------------------
module lsu_cell #(
    parameter int KEY_WIDTH = lsu_pkg::DEFAULT_KEY_WIDTH,
    parameter int CNT_W     = lsu_pkg::COUNT_PORT_W,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  lsu_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [KEY_WIDTH-1:0]  key_in,
    input  logic [KEY_WIDTH-1:0]  above,
    input  logic [KEY_WIDTH-1:0]  below,
    output logic [KEY_WIDTH-1:0]  data,
    output logic                  match
);

    logic [KEY_WIDTH-1:0] data_reg;
    logic                 match_reg;
    logic                 active;

    // Slot holds a live entry when it sits above the bottom of the stack
    assign active = CNT_W'(INDEX) < count;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            data_reg <= above;
        end
        else if (ctrl.pop)
        begin
            data_reg <= below;
        end
        if (ctrl.cmp)
        begin
            match_reg <= active && (data_reg == key_in);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule
